FILE: src/srs_pkg.sv
// ----------------------------------------------------------------------------
// Sample run statistics package
// Shared handshake status type and fixed result widths and constants.
// ----------------------------------------------------------------------------
package srs_pkg;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	localparam int STAT_W    = 32;
	localparam int CV_W      = 20;
	localparam int RATIO_W   = 24;
	localparam int RANK_W    = 7;
	localparam int PCT_COUNT = 3;

	localparam logic [CV_W-1:0]   CV_MAX  = '1;
	localparam logic [RANK_W-1:0] HUNDRED = 7'd100;

	// Percentile ranks in the order median, low, high.
	function automatic logic [RANK_W-1:0] pct_rank(input logic [1:0] idx);
		logic [RANK_W-1:0] k;
		case (idx)
			2'd0:    k = 7'd50;
			2'd1:    k = 7'd1;
			2'd2:    k = 7'd99;
			default: k = 7'd50;
		endcase
		return k;
	endfunction

endpackage

FILE: src/srs_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srs_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	output logic [NUM_W-1:0]      quo,
	output srs_pkg::unit_status_t status
);
	import srs_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign quo         = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy)
		else $error("divider finished without running");

endmodule

FILE: src/srs_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift and add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module srs_mul #(
	parameter int A_W = 64,
	parameter int B_W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [A_W-1:0]        a,
	input  logic [B_W-1:0]        b,
	output logic [A_W+B_W-1:0]    prod,
	output srs_pkg::unit_status_t status
);
	import srs_pkg::*;

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [P_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [P_W-1:0]   acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= P_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[P_W-2:0], 1'b0};
			b_q <= b_q >> 1;
		end
	end

	assign prod        = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

FILE: src/sample_run_statistics_core.sv
// ----------------------------------------------------------------------------
// Sample run statistics core
// Keeps a run of samples in a sorted memory with running sums and reports
// count, mean, extremes, percentiles, variation and tail ratio per run.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_stall   | sample, has_sample, last
//  out     | output    | out_valid / out_stall | count .. overflowed
//  cfg     | input     | cfg_we                | cfg_data (cv_limit)
//
// A sample is inserted by walking the sorted memory one entry per cycle
// through its single read port. The end of a run adds three passes of the
// shared divider, four passes of the serial multiplier, 20 square root
// steps and a pass through the percentile states for each percentile.
// Reset clears the run state; the memory needs no clearing.
// An input word is taken only when the core is idle; a finished result waits
// in the output register while the next run is taken in.
module sample_run_statistics_core #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [SAMPLE_BITS-1:0]                sample,
	input  logic                                  has_sample,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]      count,
	output logic [srs_pkg::STAT_W-1:0]            mean,
	output logic [SAMPLE_BITS-1:0]                smallest,
	output logic [SAMPLE_BITS-1:0]                largest,
	output logic [srs_pkg::STAT_W-1:0]            median,
	output logic [srs_pkg::STAT_W-1:0]            low_percentile,
	output logic [srs_pkg::STAT_W-1:0]            high_percentile,
	output logic [srs_pkg::CV_W-1:0]              variation,
	output logic [srs_pkg::RATIO_W-1:0]           tail_ratio,
	output logic                                  run_valid,
	output logic                                  overflowed,
	input  logic                                  cfg_we,
	input  logic [srs_pkg::CV_W-1:0]              cfg_data
);
	import srs_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int CW     = $clog2(MAX_SAMPLES + 1);
	localparam int AW     = $clog2(MAX_SAMPLES);
	localparam int SUM_W  = SB + CW;
	localparam int SQ_W   = 2 * SB + CW;
	localparam int A_W    = 2 * SUM_W;
	localparam int B_W    = SUM_W;
	localparam int P_W    = A_W + B_W;
	localparam int NUM_W  = P_W + 32;
	localparam int DEN_W  = (P_W > STAT_W) ? P_W : STAT_W;
	localparam int PV_W   = SB + 8;
	localparam int PVX_W  = (PV_W > STAT_W) ? PV_W : STAT_W + 1;
	localparam int POS_W  = CW + RANK_W;
	localparam int FA_W   = SB + RANK_W;
	localparam int SQT_W  = 2 * CV_W;
	localparam int BIT_W  = $clog2(CV_W);

	localparam int          FRAC_DIV   = 25;
	localparam logic [24:0] RECIP_100  = 25'd21474837;
	localparam logic [32:0] RECIP_25_W = 33'd5497558139;
	localparam logic [11:0] RECIP_25_N = 12'd2622;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SHIFT, ST_BEGIN, ST_MIN, ST_MAX, ST_MEAN_W, ST_POS, ST_POS_W,
		ST_RD_LO, ST_RD_HI, ST_FRAC1, ST_FRAC2, ST_FRAC_W, ST_TAIL, ST_TAIL_W,
		ST_VAR, ST_NQ_W, ST_S2_W, ST_R_W, ST_D_W, ST_Q_W, ST_SQRT, ST_EMIT
	} state_t;

	function automatic logic [STAT_W-1:0] sat_stat(input logic [PV_W-1:0] v);
		logic [PVX_W-1:0] x;
		x = PVX_W'(v);
		if (|(x >> STAT_W)) begin
			return '1;
		end
		return x[STAT_W-1:0];
	endfunction

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sq_q;
	logic               drop_q;
	logic [CV_W-1:0]    cv_limit_q;
	logic [SB-1:0]      s_q;
	logic               last_q;
	logic [CW-1:0]      p_q;
	logic [SB-1:0]      rd_data_q;
	logic [SB-1:0]      mem [MAX_SAMPLES];

	logic [SB-1:0]      min_q;
	logic [SB-1:0]      max_q;
	logic [STAT_W-1:0]  mean_q;
	logic [STAT_W-1:0]  pct_q [PCT_COUNT];
	logic [1:0]         pct_idx_q;
	logic [POS_W-1:0]   pos_q;
	logic [AW-1:0]      lo_q;
	logic [RANK_W-1:0]  r_q;
	logic [SB-1:0]      base_q;
	logic [SB-1:0]      fd_q;
	logic [27:0]        dq_q;
	logic [FA_W-1:0]    fa_q;
	logic [4:0]         fb_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [P_W-1:0]     nq_q;
	logic [P_W-1:0]     s2_q;
	logic [P_W-1:0]     r0_q;
	logic [SQT_W-1:0]   qt_q;
	logic [CV_W-1:0]    cv_q;
	logic [BIT_W-1:0]   bit_q;

	logic                 out_valid_q;
	logic [CW-1:0]        res_count_q;
	logic [STAT_W-1:0]    res_mean_q;
	logic [SB-1:0]        res_min_q;
	logic [SB-1:0]        res_max_q;
	logic [STAT_W-1:0]    res_med_q;
	logic [STAT_W-1:0]    res_low_q;
	logic [STAT_W-1:0]    res_high_q;
	logic [CV_W-1:0]      res_cv_q;
	logic [RATIO_W-1:0]   res_ratio_q;
	logic                 res_valid_q;
	logic                 res_drop_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [SB-1:0]        mem_wdata;
	logic [AW-1:0]        rd_addr;
	logic                 shift_go;
	logic [2*SB-1:0]      sq_prod;
	logic [POS_W-1:0]     pos;
	logic [48:0]          pos_prod;
	logic [17:0]          pos_lo;
	logic [23:0]          pos_rem;
	logic [64:0]          fd_prod;
	logic [4:0]           fd_rem;
	logic [11:0]          ft;
	logic [23:0]          ft_prod;
	logic [7:0]           ftq;
	logic [4:0]           ftr;
	logic [FA_W-1:0]      fa_next;
	logic [22:0]          fb_prod;
	logic [FA_W+5:0]      frac;
	logic [CV_W-1:0]      trial_c;
	logic [SQT_W-1:0]     trial_sq;
	logic [CW-1:0]        wd;

	logic                 div_start;
	logic [NUM_W-1:0]     div_num;
	logic [DEN_W-1:0]     div_den;
	logic [NUM_W-1:0]     div_quo;
	unit_status_t         div_status;
	logic                 mul_start;
	logic [A_W-1:0]       mul_a;
	logic [B_W-1:0]       mul_b;
	logic [P_W-1:0]       mul_prod;
	unit_status_t         mul_status;

	srs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.quo(div_quo), .status(div_status)
	);

	srs_mul #(.A_W(A_W), .B_W(B_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.prod(mul_prod), .status(mul_status)
	);

	assign shift_go  = (p_q != '0) && (rd_data_q > s_q);
	assign sq_prod   = s_q * s_q;
	assign pos       = (count_q - 1'b1) * pct_rank(pct_idx_q);
	assign pos_prod  = 49'(pos_q) * 49'(RECIP_100);
	assign pos_lo    = pos_prod[48:31];
	assign pos_rem   = 24'(pos_q) - 24'(25'(pos_lo) * 25'(HUNDRED));
	assign fd_prod   = 65'(fd_q) * 65'(RECIP_25_W);
	assign fd_rem    = 5'(fd_q - SB'(33'(dq_q) * 33'(FRAC_DIV)));
	assign ft        = 12'(fd_rem) * 12'(r_q);
	assign ft_prod   = 24'(ft) * 24'(RECIP_25_N);
	assign ftq       = ft_prod[23:16];
	assign ftr       = 5'(ft - 12'(12'(ftq) * 12'(FRAC_DIV)));
	assign fa_next   = FA_W'(dq_q) * FA_W'(r_q) + FA_W'(ftq);
	assign fb_prod   = 23'({fb_q, 6'd0}) * 23'(RECIP_25_N);
	assign frac      = {fa_q, 6'd0} + (FA_W+6)'(fb_prod[22:16]);
	assign trial_c   = cv_q | (CV_W'(1) << bit_q);
	assign trial_sq  = trial_c * trial_c;
	assign wd        = (count_q > CW'(1)) ? count_q - 1'b1 : CW'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = p_q[AW-1:0];
		mem_wdata = s_q;
		rd_addr   = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = AW'(count_q - 1'b1);
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
				if (shift_go) begin
					mem_wdata = rd_data_q;
					rd_addr   = AW'(p_q - 2'd2);
				end
			end
			ST_BEGIN: begin
				if (count_q != '0) begin
					div_start = 1'b1;
					div_num   = NUM_W'({sum_q, 8'd0});
					div_den   = DEN_W'(count_q);
				end
			end
			ST_MIN: begin
				rd_addr = AW'(count_q - 1'b1);
			end
			ST_POS_W: begin
				rd_addr = AW'(pos_lo);
			end
			ST_RD_LO: begin
				rd_addr = lo_q + 1'b1;
			end
			ST_TAIL: begin
				if (pct_q[0] != '0) begin
					div_start = 1'b1;
					div_num   = NUM_W'({pct_q[2], 16'd0});
					div_den   = DEN_W'(pct_q[0]);
				end
			end
			ST_VAR: begin
				if (sum_q != '0) begin
					mul_start = 1'b1;
					mul_a     = A_W'(sq_q);
					mul_b     = B_W'(count_q);
				end
			end
			ST_NQ_W: begin
				if (mul_status.done) begin
					mul_start = 1'b1;
					mul_a     = A_W'(sum_q);
					mul_b     = sum_q;
				end
			end
			ST_S2_W: begin
				if (mul_status.done) begin
					mul_start = 1'b1;
					mul_a     = A_W'(nq_q - mul_prod);
					mul_b     = B_W'(count_q);
				end
			end
			ST_R_W: begin
				if (mul_status.done) begin
					mul_start = 1'b1;
					mul_a     = A_W'(s2_q);
					mul_b     = B_W'(wd);
				end
			end
			ST_D_W: begin
				if (mul_status.done) begin
					div_start = 1'b1;
					div_num   = {r0_q, 32'd0};
					div_den   = DEN_W'(mul_prod);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			drop_q      <= 1'b0;
			cv_limit_q  <= CV_W'(32768);
			s_q         <= '0;
			last_q      <= 1'b0;
			p_q         <= '0;
			min_q       <= '0;
			max_q       <= '0;
			mean_q      <= '0;
			pct_q       <= '{default: '0};
			pct_idx_q   <= '0;
			pos_q       <= '0;
			lo_q        <= '0;
			r_q         <= '0;
			base_q      <= '0;
			fd_q        <= '0;
			dq_q        <= '0;
			fa_q        <= '0;
			fb_q        <= '0;
			ratio_q     <= '0;
			nq_q        <= '0;
			s2_q        <= '0;
			r0_q        <= '0;
			qt_q        <= '0;
			cv_q        <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
			res_count_q <= '0;
			res_mean_q  <= '0;
			res_min_q   <= '0;
			res_max_q   <= '0;
			res_med_q   <= '0;
			res_low_q   <= '0;
			res_high_q  <= '0;
			res_cv_q    <= '0;
			res_ratio_q <= '0;
			res_valid_q <= 1'b0;
			res_drop_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cv_limit_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						s_q    <= sample;
						last_q <= last;
						if (has_sample && count_q != CW'(MAX_SAMPLES)) begin
							p_q     <= count_q;
							state_q <= ST_SHIFT;
						end else begin
							if (has_sample) begin
								drop_q <= 1'b1;
							end
							if (last) begin
								state_q <= ST_BEGIN;
							end
						end
					end
				end
				ST_SHIFT: begin
					if (shift_go) begin
						p_q <= p_q - 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						sum_q   <= sum_q + SUM_W'(s_q);
						sq_q    <= sq_q + SQ_W'(sq_prod);
						state_q <= last_q ? ST_BEGIN : ST_IDLE;
					end
				end
				ST_BEGIN: begin
					pct_idx_q <= '0;
					state_q   <= (count_q == '0) ? ST_EMIT : ST_MIN;
				end
				ST_MIN: begin
					min_q   <= rd_data_q;
					state_q <= ST_MAX;
				end
				ST_MAX: begin
					max_q   <= rd_data_q;
					state_q <= ST_MEAN_W;
				end
				ST_MEAN_W: begin
					if (div_status.done) begin
						mean_q  <= (|div_quo[NUM_W-1:STAT_W]) ? '1 : div_quo[STAT_W-1:0];
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					pos_q   <= pos;
					state_q <= ST_POS_W;
				end
				ST_POS_W: begin
					lo_q    <= AW'(pos_lo);
					r_q     <= pos_rem[RANK_W-1:0];
					state_q <= ST_RD_LO;
				end
				ST_RD_LO: begin
					base_q  <= rd_data_q;
					state_q <= ST_RD_HI;
				end
				ST_RD_HI: begin
					if (r_q != '0) begin
						fd_q    <= rd_data_q - base_q;
						state_q <= ST_FRAC1;
					end else begin
						pct_q[pct_idx_q] <= sat_stat({base_q, 8'd0});
						if (pct_idx_q == 2'd2) begin
							state_q <= ST_TAIL;
						end else begin
							pct_idx_q <= pct_idx_q + 1'b1;
							state_q   <= ST_POS;
						end
					end
				end
				ST_FRAC1: begin
					dq_q    <= fd_prod[64:37];
					state_q <= ST_FRAC2;
				end
				ST_FRAC2: begin
					fa_q    <= fa_next;
					fb_q    <= ftr;
					state_q <= ST_FRAC_W;
				end
				ST_FRAC_W: begin
					pct_q[pct_idx_q] <= sat_stat({base_q, 8'd0} + PV_W'(frac));
					if (pct_idx_q == 2'd2) begin
						state_q <= ST_TAIL;
					end else begin
						pct_idx_q <= pct_idx_q + 1'b1;
						state_q   <= ST_POS;
					end
				end
				ST_TAIL: begin
					if (pct_q[0] == '0) begin
						ratio_q <= '0;
						state_q <= ST_VAR;
					end else begin
						state_q <= ST_TAIL_W;
					end
				end
				ST_TAIL_W: begin
					if (div_status.done) begin
						ratio_q <= (|div_quo[NUM_W-1:RATIO_W]) ? '1 : div_quo[RATIO_W-1:0];
						state_q <= ST_VAR;
					end
				end
				ST_VAR: begin
					if (sum_q == '0) begin
						cv_q    <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_NQ_W;
					end
				end
				ST_NQ_W: begin
					if (mul_status.done) begin
						nq_q    <= mul_prod;
						state_q <= ST_S2_W;
					end
				end
				ST_S2_W: begin
					if (mul_status.done) begin
						s2_q    <= mul_prod;
						state_q <= ST_R_W;
					end
				end
				ST_R_W: begin
					if (mul_status.done) begin
						r0_q    <= mul_prod;
						state_q <= ST_D_W;
					end
				end
				ST_D_W: begin
					if (mul_status.done) begin
						state_q <= ST_Q_W;
					end
				end
				ST_Q_W: begin
					if (div_status.done) begin
						if (|div_quo[NUM_W-1:SQT_W]) begin
							cv_q    <= CV_MAX;
							state_q <= ST_EMIT;
						end else begin
							qt_q    <= div_quo[SQT_W-1:0];
							cv_q    <= '0;
							bit_q   <= BIT_W'(CV_W - 1);
							state_q <= ST_SQRT;
						end
					end
				end
				ST_SQRT: begin
					if (trial_sq <= qt_q) begin
						cv_q <= trial_c;
					end
					if (bit_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						res_count_q <= count_q;
						res_drop_q  <= drop_q;
						if (count_q != '0) begin
							res_mean_q  <= mean_q;
							res_min_q   <= min_q;
							res_max_q   <= max_q;
							res_med_q   <= pct_q[0];
							res_low_q   <= pct_q[1];
							res_high_q  <= pct_q[2];
							res_cv_q    <= cv_q;
							res_ratio_q <= ratio_q;
							res_valid_q <= cv_q <= cv_limit_q;
						end else begin
							res_mean_q  <= '0;
							res_min_q   <= '0;
							res_max_q   <= '0;
							res_med_q   <= '0;
							res_low_q   <= '0;
							res_high_q  <= '0;
							res_cv_q    <= '0;
							res_ratio_q <= '0;
							res_valid_q <= 1'b0;
						end
						count_q <= '0;
						sum_q   <= '0;
						sq_q    <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign count           = res_count_q;
	assign mean            = res_mean_q;
	assign smallest        = res_min_q;
	assign largest         = res_max_q;
	assign median          = res_med_q;
	assign low_percentile  = res_low_q;
	assign high_percentile = res_high_q;
	assign variation       = res_cv_q;
	assign tail_ratio      = res_ratio_q;
	assign run_valid       = res_valid_q;
	assign overflowed      = res_drop_q;

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CW'(MAX_SAMPLES);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("sample count above capacity");

	property p_run_cleared;
		@(posedge clk) disable iff (!arst_n)
			$rose(out_valid_q) |-> (count_q == '0) && !drop_q;
	endproperty
	a_run_cleared: assert property (p_run_cleared)
		else $error("run state not cleared when result issued");

	property p_valid_nonempty;
		@(posedge clk) disable iff (!arst_n) out_valid_q && res_valid_q |-> res_count_q != '0;
	endproperty
	a_valid_nonempty: assert property (p_valid_nonempty)
		else $error("empty run reported valid");

	property p_units_exclusive;
		@(posedge clk) disable iff (!arst_n) !(div_status.busy && mul_status.busy);
	endproperty
	a_units_exclusive: assert property (p_units_exclusive)
		else $error("divider and multiplier busy together");

	property p_shift_in_range;
		@(posedge clk) disable iff (!arst_n) state_q == ST_SHIFT |-> p_q <= count_q;
	endproperty
	a_shift_in_range: assert property (p_shift_in_range)
		else $error("insertion pointer beyond stored samples");

endmodule

FILE: tb/sv/sample_run_statistics_checker.sv
// ----------------------------------------------------------------------------
// Sample run statistics checker
// Watches the input, output and register ports of the core, keeps its own
// sorted copy of each run and its sums, predicts the statistics word of every
// run end and compares each output word field by field with the oldest one.
// ----------------------------------------------------------------------------
module sample_run_statistics_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [23:0] sample,
	input  logic        has_sample,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [10:0] count,
	input  logic [31:0] mean,
	input  logic [23:0] smallest,
	input  logic [23:0] largest,
	input  logic [31:0] median,
	input  logic [31:0] low_percentile,
	input  logic [31:0] high_percentile,
	input  logic [19:0] variation,
	input  logic [23:0] tail_ratio,
	input  logic        run_valid,
	input  logic        overflowed,
	input  logic        cfg_we,
	input  logic [19:0] cfg_data,
	output int          failures,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 1024;

	typedef struct {
		logic [10:0] count;
		logic [31:0] mean;
		logic [23:0] smallest;
		logic [23:0] largest;
		logic [31:0] median;
		logic [31:0] low_pct;
		logic [31:0] high_pct;
		logic [19:0] variation;
		logic [23:0] ratio;
		logic        run_ok;
		logic        dropped;
	} run_stats_t;

	logic [23:0]  run_sorted[$];
	logic [63:0]  run_sum;
	logic [127:0] run_sq_sum;
	logic         run_dropped;
	logic [19:0]  limit_q16;
	run_stats_t   stats_due[$];

	function automatic logic [63:0] pct_q8(input int n, input int k);
		int pos;
		int lo;
		int r;
		logic [63:0] base;
		pos  = k * (n - 1);
		lo   = pos / 100;
		r    = pos % 100;
		base = {40'd0, run_sorted[lo]} << 8;
		if (r == 0 || lo + 1 >= n)
			return base;
		return base + ((64'(run_sorted[lo+1] - run_sorted[lo])) * r * 256) / 100;
	endfunction

	function automatic logic [19:0] cv_q16(input int n);
		logic [255:0] wn;
		logic [255:0] ws;
		logic [255:0] rhs;
		logic [255:0] wd;
		logic [255:0] cs;
		logic [19:0]  c;
		logic [19:0]  t;
		if (run_sum == 0)
			return '0;
		wn  = 256'(n);
		ws  = 256'(run_sum);
		wd  = 256'((n > 1) ? n - 1 : 1);
		rhs = ((wn * 256'(run_sq_sum) - ws * ws) * wn) << 32;
		c   = '0;
		for (int b = 19; b >= 0; b--) begin
			t  = c | (20'd1 << b);
			cs = 256'(t) * ws;
			if (cs * cs * wd <= rhs)
				c = t;
		end
		return c;
	endfunction

	function automatic run_stats_t close_run();
		run_stats_t  st;
		int          n;
		logic [63:0] q;
		n  = run_sorted.size();
		st = '{default: '0};
		st.count   = 11'(n);
		st.dropped = run_dropped;
		if (n > 0) begin
			st.mean      = 32'((run_sum << 8) / n);
			st.smallest  = run_sorted[0];
			st.largest   = run_sorted[n-1];
			st.median    = 32'(pct_q8(n, 50));
			st.low_pct   = 32'(pct_q8(n, 1));
			st.high_pct  = 32'(pct_q8(n, 99));
			st.variation = cv_q16(n);
			if (st.median != 0) begin
				q = {st.high_pct, 16'd0} / st.median;
				st.ratio = (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
			end
			st.run_ok = (st.variation <= limit_q16);
		end
		return st;
	endfunction

	task automatic take_sample(input logic [23:0] s);
		int p;
		if (run_sorted.size() >= CAPACITY) begin
			run_dropped = 1'b1;
		end else begin
			p = run_sorted.size();
			while (p > 0 && run_sorted[p-1] > s)
				p--;
			run_sorted.insert(p, s);
			run_sum    = run_sum + s;
			run_sq_sum = run_sq_sum + 128'(s) * 128'(s);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		run_stats_t st;
		if (!arst_n) begin
			run_sorted.delete();
			stats_due.delete();
			run_sum     = '0;
			run_sq_sum  = '0;
			run_dropped = 1'b0;
			limit_q16   = 20'd32768;
			failures    = 0;
		end else begin
			if (cfg_we)
				limit_q16 = cfg_data;
			if (in_valid && !in_stall) begin
				if (has_sample)
					take_sample(sample);
				if (last) begin
					stats_due.push_back(close_run());
					run_sorted.delete();
					run_sum     = '0;
					run_sq_sum  = '0;
					run_dropped = 1'b0;
				end
			end
			if (out_valid && !out_stall) begin
				if (stats_due.size() == 0) begin
					$error("statistics word with none expected");
					failures++;
				end else begin
					st = stats_due.pop_front();
					check_field("count", st.count, count);
					check_field("mean", st.mean, mean);
					check_field("smallest", st.smallest, smallest);
					check_field("largest", st.largest, largest);
					check_field("median", st.median, median);
					check_field("low_percentile", st.low_pct, low_percentile);
					check_field("high_percentile", st.high_pct, high_percentile);
					check_field("variation", st.variation, variation);
					check_field("tail_ratio", st.ratio, tail_ratio);
					check_field("run_valid", st.run_ok, run_valid);
					check_field("overflowed", st.dropped, overflowed);
				end
			end
		end
		pending = stats_due.size();
	end

endmodule

FILE: tb/sv/tb_sample_run_statistics_core.sv
// ----------------------------------------------------------------------------
// Sample run statistics core testbench
// Drives directed and random runs of samples through the core in bursts,
// stalls the output on its own pattern, steps the variation limit through
// several settings and reports a verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_sample_run_statistics_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 30000;
	localparam int SETTLE_CYCLES  = 1500;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [23:0] sample = '0;
	logic        has_sample = 1'b0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] count;
	logic [31:0] mean;
	logic [23:0] smallest;
	logic [23:0] largest;
	logic [31:0] median;
	logic [31:0] low_percentile;
	logic [31:0] high_percentile;
	logic [19:0] variation;
	logic [23:0] tail_ratio;
	logic        run_valid;
	logic        overflowed;
	logic        cfg_we = 1'b0;
	logic [19:0] cfg_data = '0;

	int   failures;
	int   pending;
	int   words_sent = 0;
	int   burst_left = 0;
	int   quiet_cycles = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	always #6 clk = ~clk;

	sample_run_statistics_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .has_sample(has_sample), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.count(count), .mean(mean), .smallest(smallest), .largest(largest),
		.median(median), .low_percentile(low_percentile),
		.high_percentile(high_percentile), .variation(variation),
		.tail_ratio(tail_ratio), .run_valid(run_valid), .overflowed(overflowed),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	sample_run_statistics_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .has_sample(has_sample), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.count(count), .mean(mean), .smallest(smallest), .largest(largest),
		.median(median), .low_percentile(low_percentile),
		.high_percentile(high_percentile), .variation(variation),
		.tail_ratio(tail_ratio), .run_valid(run_valid), .overflowed(overflowed),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.failures(failures), .pending(pending)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// The receiver mixes calm, light and heavy stall stretches, and once holds
	// off for a long time so that the core fills and stalls its input.
	initial begin
		int mode;
		int mode_left;
		mode      = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (4000) @(negedge clk);
				hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 9) < 3);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 5))
			0:       return 24'd0;
			1:       return 24'hFFFFFF;
			2:       return 24'($urandom_range(0, 15));
			3:       return 24'($urandom_range(24'hFFFF00, 24'hFFFFFF));
			4:       return 24'($urandom) & 24'($urandom);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic put_word(input logic [23:0] s, input logic h, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		in_valid   <= 1'b1;
		sample     <= s;
		has_sample <= h;
		last       <= l;
		#1;
		while (in_stall) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		words_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [19:0] v);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic send_run(input int n);
		logic end_with_sample;
		end_with_sample = (n > 0) && $urandom_range(0, 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				put_word(24'($urandom), 1'b0, 1'b0);
			put_word(pick_sample(), 1'b1, end_with_sample && (i == n - 1));
		end
		if (!end_with_sample)
			put_word(24'($urandom), 1'b0, 1'b1);
	endtask

	task automatic random_runs(input int words_target);
		while (words_sent < words_target) begin
			case ($urandom_range(0, 9))
				0:       send_run(0);
				1:       send_run($urandom_range(20, 60));
				default: send_run($urandom_range(1, 12));
			endcase
		end
	endtask

	initial begin
		logic [19:0] limits[5];
		limits = '{20'd0, 20'hFFFFF, 20'($urandom_range(0, 131071)),
			20'($urandom), 20'd32768};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed runs under the reset limit.
		put_word(24'hABCDEF, 1'b0, 1'b1);
		put_word(24'h123456, 1'b0, 1'b0);
		put_word(24'd0, 1'b1, 1'b1);
		put_word(24'hFFFFFF, 1'b1, 1'b1);
		put_word(24'hFFFFFF, 1'b1, 1'b0);
		put_word(24'd0, 1'b1, 1'b0);
		put_word(24'd0, 1'b0, 1'b1);
		put_word(24'd0, 1'b1, 1'b0);
		put_word(24'd0, 1'b1, 1'b0);
		put_word(24'hFFFFFF, 1'b1, 1'b1);
		put_word(24'd1000, 1'b1, 1'b0);
		put_word(24'd1000, 1'b1, 1'b0);
		put_word(24'd1000, 1'b1, 1'b1);
		for (int i = 0; i < 7; i++)
			put_word(24'd700 - 24'(i * 100), 1'b1, i == 6);
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			write_limit(limits[ph]);
			if (ph == 1) begin
				// One large sample among many zeros saturates the variation.
				for (int i = 0; i < 260; i++)
					put_word(24'd0, 1'b1, 1'b0);
				put_word(24'hFFFFFF, 1'b1, 1'b1);
			end
			if (ph == 2)
				hold_req = 1'b1;
			random_runs(words_sent + 55);
			wait_idle();
		end

		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
